>>> rtl/core/lpd_pkg.sv
package lpd_pkg;

    localparam int CfgWidth = 16;
    localparam int CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_LINK_ENABLE = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_MIN_LENGTH  = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_MAX_LENGTH  = 2'd2;

    localparam logic [15:0] MIN_LENGTH_RESET = 16'd1;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'd1500;

    localparam logic EVENT_PAYLOAD = 1'b0;
    localparam logic EVENT_ERROR   = 1'b1;

    typedef struct packed {
        logic        link_enable;
        logic [15:0] min_length;
        logic [15:0] max_length;
    } cfg_t;

    typedef struct packed {
        logic [31:0] framing_errors_seen;
        logic [31:0] payload_bytes_seen;
        logic [31:0] packets_seen;
        logic [15:0] rejected_length;
        logic        last_of_packet;
        logic        first_of_packet;
        logic [7:0]  payload_byte;
        logic        event_kind;
    } result_t;

endpackage

>>> rtl/core/lpd_core.sv
module lpd_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  lpd_pkg::cfg_t    cfg,
    input  logic             go,
    input  logic [7:0]       stream_byte,
    input  logic             taken,
    output logic             result_valid,
    output lpd_pkg::result_t result
);

    typedef enum logic [1:0] {
        PH_LEN_HIGH = 2'd0,
        PH_LEN_LOW  = 2'd1,
        PH_PAYLOAD  = 2'd2
    } phase_t;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [7:0]       length_high_reg;
    logic [7:0]       length_high_next;
    logic [15:0]      length_total_reg;
    logic [15:0]      length_total_next;
    logic [15:0]      bytes_left_reg;
    logic [15:0]      bytes_left_next;
    logic [31:0]      packet_counter_reg;
    logic [31:0]      packet_counter_next;
    logic [31:0]      byte_counter_reg;
    logic [31:0]      byte_counter_next;
    logic [31:0]      error_counter_reg;
    logic [31:0]      error_counter_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    lpd_pkg::result_t result_reg;
    lpd_pkg::result_t result_next;

    logic [15:0]      length_value;
    logic             length_bad;
    logic             first_byte;
    logic             last_byte;
    logic             has_result;

    assign length_value = {length_high_reg, stream_byte};
    assign length_bad   = (length_value < cfg.min_length) || (length_value > cfg.max_length);
    assign first_byte   = (bytes_left_reg == length_total_reg);
    assign last_byte    = (bytes_left_reg <= 16'd1);

    always_comb
    begin
        phase_next          = phase_reg;
        length_high_next    = length_high_reg;
        length_total_next   = length_total_reg;
        bytes_left_next     = bytes_left_reg;
        packet_counter_next = packet_counter_reg;
        byte_counter_next   = byte_counter_reg;
        error_counter_next  = error_counter_reg;
        has_result          = 1'b0;
        result_next.event_kind      = lpd_pkg::EVENT_PAYLOAD;
        result_next.payload_byte    = 8'd0;
        result_next.first_of_packet = 1'b0;
        result_next.last_of_packet  = 1'b0;
        result_next.rejected_length = 16'd0;

        if (cfg.link_enable)
        begin
            unique case (phase_reg)
                PH_LEN_LOW:
                begin
                    if (length_bad)
                    begin
                        error_counter_next = error_counter_reg + 32'd1;
                        phase_next = PH_LEN_HIGH;
                        has_result = 1'b1;
                        result_next.event_kind = lpd_pkg::EVENT_ERROR;
                        result_next.rejected_length = length_value;
                    end
                    else if (length_value == 16'd0)
                    begin
                        packet_counter_next = packet_counter_reg + 32'd1;
                        length_total_next = 16'd0;
                        bytes_left_next = 16'd0;
                        phase_next = PH_LEN_HIGH;
                    end
                    else
                    begin
                        length_total_next = length_value;
                        bytes_left_next = length_value;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    has_result = 1'b1;
                    result_next.payload_byte = stream_byte;
                    result_next.first_of_packet = first_byte;
                    result_next.last_of_packet = last_byte;
                    if (last_byte)
                    begin
                        packet_counter_next = packet_counter_reg + 32'd1;
                        byte_counter_next = byte_counter_reg + {16'd0, length_total_reg};
                        bytes_left_next = 16'd0;
                        phase_next = PH_LEN_HIGH;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - 16'd1;
                    end
                end
                default:
                begin
                    length_high_next = stream_byte;
                    phase_next = PH_LEN_LOW;
                end
            endcase
        end

        result_next.packets_seen        = packet_counter_next;
        result_next.payload_bytes_seen  = byte_counter_next;
        result_next.framing_errors_seen = error_counter_next;

        if (go)
        begin
            result_valid_next = has_result;
        end
        else
        begin
            result_valid_next = result_valid_reg && !taken;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_LEN_HIGH;
            length_high_reg    <= 8'd0;
            length_total_reg   <= 16'd0;
            bytes_left_reg     <= 16'd0;
            packet_counter_reg <= 32'd0;
            byte_counter_reg   <= 32'd0;
            error_counter_reg  <= 32'd0;
            result_valid_reg   <= 1'b0;
            result_reg         <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (go)
            begin
                phase_reg          <= phase_next;
                length_high_reg    <= length_high_next;
                length_total_reg   <= length_total_next;
                bytes_left_reg     <= bytes_left_next;
                packet_counter_reg <= packet_counter_next;
                byte_counter_reg   <= byte_counter_next;
                error_counter_reg  <= error_counter_next;
                if (has_result)
                begin
                    result_reg <= result_next;
                end
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> rtl/core/length_prefix_deframer.sv
// Length-prefixed deframer for a received byte stream.
// Bytes enter on the s_axis channel, one item per byte. Each packet is led by a
// two-byte big-endian length; lengths outside min_length..max_length give a
// framing error item and the next two bytes are read as a new length.
// Result items leave on the m_axis channel: payload bytes with first and last
// marks, or error items carrying the rejected length, each with running
// packet, payload byte and error counts that wrap at 32 bits.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while idle, and the block itself does not enforce this.
// An accepted byte passes through the input register and then through the
// decode logic into the result register. Throughput is one byte per cycle
// while the receiver takes results, with one state update per byte moved.
// When the receiver stalls, the result register holds its item and the input
// register holds one more byte; s_axis_tready then falls until the result is
// taken, and bytes that give no result pass while the result slot is free.
// Reset clears the phase, the counters and both valid flags, and sets the
// link disabled with lengths 1 to 1500 allowed.
module length_prefix_deframer
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // stream_byte
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // payload_byte, rejected_length, packets_seen, payload_bytes_seen,
    // framing_errors_seen
    output logic [119:0]  m_axis_tdata,
    output logic          m_axis_tlast,   // last_of_packet
    output logic [1:0]    m_axis_tuser,   // event_kind, first_of_packet
    input  logic          cfg_we,
    input  logic [lpd_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [lpd_pkg::CfgWidth-1:0]      cfg_data
);

    lpd_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             go;
    logic             result_valid;
    lpd_pkg::result_t result;

    assign go            = in_valid_reg && (!result_valid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_enable <= 1'b0;
            cfg_reg.min_length  <= lpd_pkg::MIN_LENGTH_RESET;
            cfg_reg.max_length  <= lpd_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpd_pkg::CFG_LINK_ENABLE: cfg_reg.link_enable <= cfg_data[0];
                lpd_pkg::CFG_MIN_LENGTH:  cfg_reg.min_length  <= cfg_data;
                lpd_pkg::CFG_MAX_LENGTH:  cfg_reg.max_length  <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    lpd_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .go           (go),
        .stream_byte  (in_byte_reg),
        .taken        (m_axis_tready),
        .result_valid (result_valid),
        .result       (result)
    );

    assign m_axis_tvalid = result_valid;
    assign m_axis_tdata  = {result.framing_errors_seen, result.payload_bytes_seen,
                            result.packets_seen, result.rejected_length,
                            result.payload_byte};
    assign m_axis_tlast  = result.last_of_packet;
    assign m_axis_tuser  = {result.first_of_packet, result.event_kind};

endmodule
